@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPLY(name, cond, prop, text) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(text);

// Next-cycle implication.
`define CHK_NEXT(name, cond, prop, text) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(text);

`endif

@@ hdl/sha256_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 engine package
// Constants, sequencer states and the round helper functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

   // Width of the bit length written into the final block (32..64).
   localparam int LENGTH_BITS = 64;
   localparam logic [63:0] LEN_MASK = (LENGTH_BITS >= 64) ? {64{1'b1}} :
                                      ((64'd1 << LENGTH_BITS) - 64'd1);

   localparam logic [7:0] PAD_MARKER = 8'h80;
   localparam logic [5:0] LEN_POS    = 6'd56;

   localparam logic [31:0] IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FOLD,
      ST_SEND
   } state_type;

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      ror = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big0(input logic [31:0] x);
      big0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
   endfunction

   function automatic logic [31:0] big1(input logic [31:0] x);
      big1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
   endfunction

   function automatic logic [31:0] sml0(input logic [31:0] x);
      sml0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] sml1(input logic [31:0] x);
      sml1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
   endfunction

endpackage

@@ hdl/sha256_hash_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Streaming message digest: bytes in, eight big-endian digest words out.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Carries
//  --------+-----+--------------------------------------------------------
//  req_    | in  | one message byte per word, carries_byte flag, last flag
//  rsp_    | out | one 32-bit digest word per word, H0 first, tlast on H7
//
// The byte that completes a 64-byte block starts one compression: the
// rounds of the shared round unit, then a fold of the working variables
// into the chaining value. Closing a message fills the rest of the open
// block one padding byte per cycle and compresses it; when the length did
// not fit, a second block is padded and compressed. Then the eight digest
// words are offered.
// Reset is synchronous and active high; no clearing pass is needed.
// req_tready is low while padding, compressing or sending the digest.
//
// The block buffer doubles as the message schedule: bytes shift in at the
// low end, and during the rounds the sixteen words shift by one word per
// round while the newest schedule word enters at the bottom.
`include "assert_macros.svh"

module sha256_hash_engine (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] carries_byte
   input  logic        req_tlast,   // message ends with this word

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic        rsp_tlast    // eighth digest word
);

   sha256_pkg::state_type state_ff, state_in;

   logic [5:0]         fill_ff, fill_in;       // bytes held in the block
   logic [60:0]        msg_ff, msg_in;         // bytes in the message
   logic               pad_ff, pad_in;         // message is being closed
   logic               marker_ff, marker_in;   // 0x80 marker already placed
   logic               lenok_ff, lenok_in;     // this block carries the length
   logic [5:0]         rnd_ff, rnd_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic [31:0]        chain_ff [8];
   logic [31:0]        chain_in [8];
   logic [31:0]        v_ff [8];
   logic [31:0]        v_in [8];
   logic [15:0][31:0]  blk_ff, blk_in;

   logic        req_acc;
   logic        rsp_acc;
   logic        ins_en;
   logic [7:0]  ins_byte;
   logic [7:0]  pad_byte;
   logic [63:0] bit_len;
   logic [63:0] len_shift;
   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] w_new;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // Padding byte: the marker first, then zeros, and the big-endian bit
   // length in the last eight places of the block that closes the message.
   assign bit_len   = {msg_ff, 3'b000} & sha256_pkg::LEN_MASK;
   assign len_shift = bit_len << {fill_ff[2:0], 3'b000};

   always_comb begin
      if (!marker_ff) begin
         pad_byte = sha256_pkg::PAD_MARKER;
      end else if (lenok_ff && (fill_ff >= sha256_pkg::LEN_POS)) begin
         pad_byte = len_shift[63:56];
      end else begin
         pad_byte = 8'h00;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sha256_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser && (fill_ff == 6'd63)) begin
                  state_in = sha256_pkg::ST_ROUND;
               end else if (req_tlast) begin
                  state_in = sha256_pkg::ST_PAD;
               end
            end
         end
         sha256_pkg::ST_PAD: begin
            if (fill_ff == 6'd63) begin
               state_in = sha256_pkg::ST_ROUND;
            end
         end
         sha256_pkg::ST_ROUND: begin
            if (rnd_ff == 6'd63) begin
               state_in = sha256_pkg::ST_FOLD;
            end
         end
         sha256_pkg::ST_FOLD: begin
            if (!pad_ff) begin
               state_in = sha256_pkg::ST_IDLE;
            end else if (lenok_ff) begin
               state_in = sha256_pkg::ST_SEND;
            end else begin
               state_in = sha256_pkg::ST_PAD;
            end
         end
         sha256_pkg::ST_SEND: begin
            if (rsp_acc && (cnt_ff == 3'd7)) begin
               state_in = sha256_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sha256_pkg::ST_IDLE;
         end
      endcase
   end

   // Port outputs.
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         sha256_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         sha256_pkg::ST_SEND: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
            rsp_tvalid = 1'b0;
         end
      endcase
   end

   // The chaining value rotates as words leave, so the next digest word always sits in front.
   assign rsp_tdata = chain_ff[0];
   assign rsp_tlast = (cnt_ff == 3'd7);

   // Datapath: byte insertion, the shared round unit, the fold after each block and the digest rotation.
   always_comb begin
      fill_in   = fill_ff;
      msg_in    = msg_ff;
      pad_in    = pad_ff;
      marker_in = marker_ff;
      lenok_in  = lenok_ff;
      rnd_in    = rnd_ff;
      cnt_in    = cnt_ff;
      chain_in  = chain_ff;
      v_in      = v_ff;
      blk_in    = blk_ff;

      t1    = v_ff[7] + sha256_pkg::big1(v_ff[4])
              + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
              + sha256_pkg::ROUND_K[rnd_ff] + blk_ff[15];
      t2    = sha256_pkg::big0(v_ff[0])
              + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      w_new = sha256_pkg::sml1(blk_ff[1]) + blk_ff[6]
              + sha256_pkg::sml0(blk_ff[14]) + blk_ff[15];

      ins_en   = 1'b0;
      ins_byte = pad_byte;
      case (state_ff)
         sha256_pkg::ST_IDLE: begin
            ins_en   = req_acc && req_tuser;
            ins_byte = req_tdata;
            if (req_acc) begin
               if (req_tuser) begin
                  msg_in = msg_ff + 61'd1;
               end
               if (req_tlast) begin
                  pad_in = 1'b1;
               end
            end
         end
         sha256_pkg::ST_PAD: begin
            ins_en = 1'b1;
            if (!marker_ff) begin
               marker_in = 1'b1;
               lenok_in  = (fill_ff < sha256_pkg::LEN_POS);
            end
         end
         sha256_pkg::ST_ROUND: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            blk_in  = {blk_ff[14:0], w_new};
            rnd_in  = rnd_ff + 6'd1;
         end
         sha256_pkg::ST_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + v_ff[i];
            end
            // A block that closed without room for the length is followed by one that
            // holds zeros and the length, led by the marker if it was not yet placed.
            if (pad_ff && !lenok_ff) begin
               lenok_in = marker_ff;
            end
         end
         sha256_pkg::ST_SEND: begin
            if (rsp_acc) begin
               cnt_in = cnt_ff + 3'd1;
               for (int i = 0; i < 7; i++) begin
                  chain_in[i] = chain_ff[i + 1];
               end
               chain_in[7] = chain_ff[0];
               if (cnt_ff == 3'd7) begin
                  chain_in  = sha256_pkg::IV;
                  msg_in    = '0;
                  pad_in    = 1'b0;
                  marker_in = 1'b0;
                  lenok_in  = 1'b0;
               end
            end
         end
         default: begin
            ins_en = 1'b0;
         end
      endcase

      if (ins_en) begin
         blk_in  = (blk_ff << 8) | {504'd0, ins_byte};
         fill_in = fill_ff + 6'd1;
         if (fill_ff == 6'd63) begin
            rnd_in = 6'd0;
            v_in   = chain_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sha256_pkg::ST_IDLE;
         fill_ff   <= '0;
         msg_ff    <= '0;
         pad_ff    <= 1'b0;
         marker_ff <= 1'b0;
         lenok_ff  <= 1'b0;
         rnd_ff    <= '0;
         cnt_ff    <= '0;
         chain_ff  <= sha256_pkg::IV;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         msg_ff    <= msg_in;
         pad_ff    <= pad_in;
         marker_ff <= marker_in;
         lenok_ff  <= lenok_in;
         rnd_ff    <= rnd_in;
         cnt_ff    <= cnt_in;
         chain_ff  <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      blk_ff <= blk_in;
   end

   // The input side is closed whenever a digest word is on offer.
   `CHK_IMPLY(a_no_overlap, rsp_tvalid, !req_tready, "input open while digest pending")
   // The last round always hands over to the fold.
   `CHK_NEXT(a_round_end, (state_ff == sha256_pkg::ST_ROUND) && (rnd_ff == 6'd63), (state_ff == sha256_pkg::ST_FOLD), "rounds did not end in fold")
   // A digest is only sent after the block holding the length was folded in.
   `CHK_IMPLY(a_send_ready, state_ff == sha256_pkg::ST_SEND, (fill_ff == 6'd0) && lenok_ff && marker_ff, "digest sent before length block")
   // The final digest word restores the initial chaining value.
   `CHK_NEXT(a_restart, rsp_acc && rsp_tlast, (chain_ff[0] == sha256_pkg::IV[0]) && (msg_ff == 61'd0), "engine not restarted after digest")

endmodule
